[sv/bbf_pkg.sv]
`timescale 1ns / 1ps
package bbf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_KERNEL = 15;

  localparam int CFGW = 11;
  localparam int COLW = 11;
  localparam int ROWW = 12;
  localparam int HALFW = 4;
  localparam int SLOTW = 5;
  localparam int QW = 23;

  localparam logic [CFGW-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFGW-1:0] RST_HEIGHT = 11'd480;
  localparam logic [3:0]      RST_KERNEL = 4'd9;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  localparam logic [7:0] WHITE = 8'd255;

  typedef struct packed {
    logic [23:0]      val;
    logic [ROWW-1:0]  row;
    logic [COLW-1:0]  col;
    logic [SLOTW-1:0] slot;
    logic [HALFW-1:0] half;
    logic [COLW-1:0]  w;
    logic [COLW-1:0]  emit_col;
    logic             emit;
    logic             last;
  } entry_t;

endpackage

[sv/box_blur_filter_core.sv]
`timescale 1ns / 1ps
// Box blur over three-channel 8-bit pixels in raster order: each result is the
// floor mean of the k x k window around its pixel, border pixels count as 255.
// Frame size and kernel are sampled at the first pixel of each frame. Send
// flush beats after the frame so the last h rows and h pixels come out. A
// front stage classifies beats and feeds a two-entry queue; the back stage
// works one item at a time. For each item it reads the line memory once for
// each of the 2h rows above (address in S_RADDR, sum in S_RACC), writes the
// column sum and, when the item yields a result, adds up the 2h + 1 columns
// of the window, runs one divider step per bit of the window sum (16 at the
// default kernel limit) and holds the result until taken; h is half the kernel size.
module box_blur_filter_core #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = bbf_pkg::DEF_MAX_KERNEL
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [bbf_pkg::CFGW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [7:0]               ch0,
  input  logic [7:0]               ch1,
  input  logic [7:0]               ch2,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_ch0,
  output logic [7:0]               out_ch1,
  output logic [7:0]               out_ch2,
  output logic                     last_of_frame
);
  bbf_pkg::entry_t wentry, rentry;
  logic push, full, pop, qvalid;

  bbf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .kind, .ch0, .ch1, .ch2, .full, .push, .entry(wentry)
  );

  bbf_fifo u_fifo (
    .clk, .rst, .push, .wdata(wentry), .full, .pop, .valid(qvalid), .rdata(rentry)
  );

  bbf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_back (
    .clk, .rst, .valid(qvalid), .entry(rentry), .pop, .out_valid, .out_stall,
    .out_ch0, .out_ch1, .out_ch2, .last_of_frame
  );
endmodule

[sv/bbf_front.sv]
`timescale 1ns / 1ps
module bbf_front #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = bbf_pkg::DEF_MAX_KERNEL
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bbf_pkg::CFGW-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [7:0]                ch0,
  input  logic [7:0]                ch1,
  input  logic [7:0]                ch2,
  input  logic                      full,
  output logic                      push,
  output bbf_pkg::entry_t           entry
);
  localparam int KMAX = (MAX_KERNEL - 1) | 1;

  logic [bbf_pkg::CFGW-1:0]  frame_width, frame_height;
  logic [3:0]                kernel_size;
  logic [bbf_pkg::COLW-1:0]  cur_w, w_new, w_e;
  logic [bbf_pkg::CFGW-1:0]  cur_h, h_new, h_e;
  logic [bbf_pkg::HALFW-1:0] cur_half, half_new, half_e;
  logic [4:0]                k_new;
  logic [bbf_pkg::ROWW-1:0]  row;
  logic [bbf_pkg::COLW-1:0]  col, emit_col;
  logic [bbf_pkg::SLOTW-1:0] slot;
  logic [bbf_pkg::QW-1:0]    q, emitted, total, lead;
  logic                      first, drop, white, emits, last, accept;

  always_comb begin
    first = (q == '0);
    if (frame_width == '0) w_new = bbf_pkg::COLW'(1);
    else if (int'(frame_width) > MAX_WIDTH) w_new = bbf_pkg::COLW'(MAX_WIDTH);
    else w_new = frame_width;
    h_new = (frame_height == '0) ? bbf_pkg::CFGW'(1) : frame_height;
    k_new = {1'b0, kernel_size | 4'd1};
    if (int'(k_new) > KMAX) k_new = 5'(KMAX);
    half_new = bbf_pkg::HALFW'(k_new >> 1);
    w_e = first ? w_new : cur_w;
    h_e = first ? h_new : cur_h;
    half_e = first ? half_new : cur_half;
    total = bbf_pkg::QW'(w_e) * bbf_pkg::QW'(h_e);
    lead = bbf_pkg::QW'(half_e) * bbf_pkg::QW'(w_e) + bbf_pkg::QW'(half_e);
    white = (q >= total);
    drop = kind && !white;
    emits = (q >= lead);
    last = emits && (emitted + 1'b1 == total);
    accept = in_valid && !in_stall;
    push = accept && !drop;
    in_stall = full;
    entry.val = white ? 24'hFFFFFF : {ch2, ch1, ch0};
    entry.row = row;
    entry.col = col;
    entry.slot = slot;
    entry.half = half_e;
    entry.w = w_e;
    entry.emit_col = emit_col;
    entry.emit = emits;
    entry.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= bbf_pkg::RST_WIDTH;
      frame_height <= bbf_pkg::RST_HEIGHT;
      kernel_size <= bbf_pkg::RST_KERNEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbf_pkg::REG_WIDTH: frame_width <= cfg_data;
        bbf_pkg::REG_HEIGHT: frame_height <= cfg_data;
        bbf_pkg::REG_KERNEL: kernel_size <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w <= '0;
      cur_h <= '0;
      cur_half <= '0;
      row <= '0;
      col <= '0;
      slot <= '0;
      q <= '0;
      emitted <= '0;
      emit_col <= '0;
    end else if (push) begin
      if (first) begin
        cur_w <= w_new;
        cur_h <= h_new;
        cur_half <= half_new;
      end
      if (last) begin
        row <= '0;
        col <= '0;
        slot <= '0;
        q <= '0;
        emitted <= '0;
        emit_col <= '0;
      end else begin
        q <= q + 1'b1;
        if (col + 1'b1 >= w_e) begin
          col <= '0;
          row <= row + 1'b1;
          slot <= (int'(slot) == MAX_KERNEL - 1) ? '0 : slot + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        if (emits) begin
          emitted <= emitted + 1'b1;
          emit_col <= (emit_col + 1'b1 >= w_e) ? '0 : emit_col + 1'b1;
        end
      end
    end
  end
endmodule

[sv/bbf_fifo.sv]
`timescale 1ns / 1ps
module bbf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bbf_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output bbf_pkg::entry_t rdata
);
  bbf_pkg::entry_t mem [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[sv/bbf_back.sv]
`timescale 1ns / 1ps
module bbf_back #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = bbf_pkg::DEF_MAX_KERNEL
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  input  bbf_pkg::entry_t entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_ch0,
  output logic [7:0]      out_ch1,
  output logic [7:0]      out_ch2,
  output logic            last_of_frame
);
  localparam int KMAX = (MAX_KERNEL - 1) | 1;
  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CSW = $clog2(255 * KMAX + 1);
  localparam int SW = $clog2(255 * KMAX * KMAX + 1);
  localparam int KKW = $clog2(KMAX * KMAX + 1);
  localparam int CW = $clog2(SW + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RADDR = 7'b0000010,
    S_RACC  = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_WIN   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  bbf_pkg::entry_t e;
  logic [23:0] mem [DEPTH];
  logic [23:0] rd;
  logic [CSW-1:0] cs [3];
  logic [3*CSW-1:0] colsum [MAX_KERNEL];
  logic [DW-1:0] cnt, span;
  logic [SW-1:0] acc [3];
  logic [SW:0] rem [3];
  logic [SW:0] rem_sh [3];
  logic [KMAX > 0 ? 4 : 4:0] k;
  logic [KKW-1:0] kk;
  logic [CW-1:0] dcnt;
  logic [bbf_pkg::SLOTW-1:0] rslot;
  logic [AW-1:0] raddr, waddr;
  logic [bbf_pkg::COLW:0] cpos;
  logic in_rng;
  logic [SW-1:0] wterm;

  always_comb begin
    span = DW'({e.half, 1'b0});
    k = 5'({e.half, 1'b1});
    kk = KKW'(k * k);
    if (int'(e.slot) >= int'(cnt)) rslot = e.slot - bbf_pkg::SLOTW'(cnt);
    else rslot = bbf_pkg::SLOTW'(int'(e.slot) + MAX_KERNEL - int'(cnt));
    raddr = AW'(int'(rslot) * MAX_WIDTH + int'(e.col));
    waddr = AW'(int'(e.slot) * MAX_WIDTH + int'(e.col));
    cpos = {1'b0, e.emit_col} + (bbf_pkg::COLW+1)'(e.half);
    in_rng = (cpos >= (bbf_pkg::COLW+1)'(cnt)) &&
             (cpos - (bbf_pkg::COLW+1)'(cnt) < {1'b0, e.w});
    wterm = SW'(255 * int'(k));
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem[c][SW-1:0], acc[c][SW-1]};
    end
    pop = (state == S_IDLE) && valid;
    out_valid = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) mem[waddr] <= e.val;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int d = 0; d < MAX_KERNEL; d++) colsum[d] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (valid) begin
            e <= entry;
            for (int c = 0; c < 3; c++) cs[c] <= CSW'(entry.val[8*c +: 8]);
            cnt <= DW'(1);
            state <= (entry.half == '0) ? S_WRITE : S_RADDR;
          end
        end
        S_RADDR: state <= S_RACC;
        S_RACC: begin
          for (int c = 0; c < 3; c++) begin
            cs[c] <= cs[c] + ((int'(e.row) >= int'(cnt)) ? CSW'(rd[8*c +: 8])
                                                         : CSW'(bbf_pkg::WHITE));
          end
          if (cnt == span) begin
            state <= S_WRITE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_RADDR;
          end
        end
        S_WRITE: begin
          for (int d = 1; d < MAX_KERNEL; d++) colsum[d] <= colsum[d-1];
          colsum[0] <= {cs[2], cs[1], cs[0]};
          cnt <= '0;
          for (int c = 0; c < 3; c++) acc[c] <= '0;
          state <= e.emit ? S_WIN : S_IDLE;
        end
        S_WIN: begin
          for (int c = 0; c < 3; c++) begin
            acc[c] <= acc[c] + (in_rng ? SW'(colsum[cnt][CSW*c +: CSW]) : wterm);
            rem[c] <= '0;
          end
          dcnt <= '0;
          if (cnt == span) state <= S_DIV;
          else cnt <= cnt + 1'b1;
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (rem_sh[c] >= (SW+1)'(kk)) begin
              rem[c] <= rem_sh[c] - (SW+1)'(kk);
              acc[c] <= {acc[c][SW-2:0], 1'b1};
            end else begin
              rem[c] <= rem_sh[c];
              acc[c] <= {acc[c][SW-2:0], 1'b0};
            end
          end
          dcnt <= dcnt + 1'b1;
          if (int'(dcnt) == SW - 1) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch0 = acc[0][7:0];
  assign out_ch1 = acc[1][7:0];
  assign out_ch2 = acc[2][7:0];
  assign last_of_frame = e.last;

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_RADDR || state == S_WRITE))
    else $error("pop did not start work");
  a_racc_after_raddr: assert property (@(posedge clk) disable iff (rst)
    state == S_RACC |-> $past(state) == S_RADDR)
    else $error("accumulate without read");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> int'(dcnt) < SW)
    else $error("divider overran");
  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DIV)
    else $error("result without division");
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int LINE_W = 1024;
  localparam int LINE_ROWS = 15;
  localparam int KCAP = 15;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_LIMIT = 20000;
  localparam int ITEM_GOAL = 1450;

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       last;
  } blur_px_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [bbf_pkg::CFGW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic kind;
  logic [7:0] ch0, ch1, ch2;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_ch0, out_ch1, out_ch2;
  logic last_of_frame;

  box_blur_filter_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .ch0(ch0), .ch1(ch1), .ch2(ch2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2),
    .last_of_frame(last_of_frame)
  );

  blur_px_t pending_px[$];
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit stall_quiet = 0;

  // blur predictor state
  logic [23:0] line_mem [0:LINE_ROWS*LINE_W-1];
  logic [35:0] col_sum [0:KCAP-1];
  int unsigned reg_w, reg_h, reg_k;
  int unsigned pos_row, pos_col, emit_cnt;
  int unsigned frm_w, frm_h, frm_half;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic blur_predict(input logic k_in, input logic [23:0] px, output bit taken);
    int unsigned q, total, kk, lead, c, i;
    int j, colp;
    int unsigned cs[3];
    logic [23:0] val, v;
    logic [35:0] pk;
    blur_px_t r;
    taken = 0;
    if (pos_row == 0 && pos_col == 0) begin
      if (k_in) return;
      frm_w = reg_w == 0 ? 1 : (reg_w > LINE_W ? LINE_W : reg_w);
      frm_h = reg_h == 0 ? 1 : reg_h;
      kk = reg_k | 1;
      if (kk > KCAP) kk = KCAP;
      frm_half = kk >> 1;
    end
    kk = 2 * frm_half + 1;
    q = pos_row * frm_w + pos_col;
    total = frm_w * frm_h;
    if (q < total && k_in) return;
    taken = 1;
    val = (q >= total) ? 24'hFFFFFF : px;
    for (int ch = 0; ch < 3; ch++) cs[ch] = val[ch*8 +: 8];
    for (i = 1; i <= 2 * frm_half; i++) begin
      v = 24'hFFFFFF;
      if (pos_row >= i) v = line_mem[((pos_row - i) % LINE_ROWS) * LINE_W + pos_col];
      for (int ch = 0; ch < 3; ch++) cs[ch] += v[ch*8 +: 8];
    end
    line_mem[(pos_row % LINE_ROWS) * LINE_W + pos_col] = val;
    for (int d = KCAP - 1; d > 0; d--) col_sum[d] = col_sum[d-1];
    col_sum[0] = {12'(cs[2]), 12'(cs[1]), 12'(cs[0])};
    pos_col++;
    if (pos_col >= frm_w) begin
      pos_col = 0;
      pos_row++;
    end
    lead = frm_half * frm_w + frm_half;
    if (q < lead) return;
    c = emit_cnt % frm_w;
    cs[0] = 0; cs[1] = 0; cs[2] = 0;
    for (j = -int'(frm_half); j <= int'(frm_half); j++) begin
      colp = int'(c) + j;
      if (colp < 0 || colp >= int'(frm_w)) begin
        for (int ch = 0; ch < 3; ch++) cs[ch] += 255 * kk;
      end else begin
        pk = col_sum[int'(frm_half) - j];
        for (int ch = 0; ch < 3; ch++) cs[ch] += pk[ch*12 +: 12];
      end
    end
    r.c0 = 8'(cs[0] / (kk * kk));
    r.c1 = 8'(cs[1] / (kk * kk));
    r.c2 = 8'(cs[2] / (kk * kk));
    r.last = (emit_cnt + 1 == total);
    pending_px.push_back(r);
    emit_cnt++;
    if (r.last) begin
      pos_row = 0;
      pos_col = 0;
      emit_cnt = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input logic k_in, input logic [23:0] px);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    kind <= k_in;
    {ch2, ch1, ch0} <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blur_predict(k_in, px, taken);
    if (taken) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [1:0] idx, input int unsigned value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[bbf_pkg::CFGW-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      bbf_pkg::REG_WIDTH:  reg_w = value & 11'h7FF;
      bbf_pkg::REG_HEIGHT: reg_h = value & 11'h7FF;
      bbf_pkg::REG_KERNEL: reg_k = value & 4'hF;
      default: ;
    endcase
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned k);
    set_cfg(bbf_pkg::REG_WIDTH, w);
    set_cfg(bbf_pkg::REG_HEIGHT, h);
    set_cfg(bbf_pkg::REG_KERNEL, k);
  endtask

  function automatic logic [23:0] rand_px();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // one frame: real pixels, then flush beats (noise_pct of them of the other kind) until the last result is predicted
  task automatic run_frame(input int noise_pct, input int pause_at);
    int n;
    n = 0;
    send_beat(0, rand_px());
    while (pos_row != 0 || pos_col != 0) begin
      if (n == pause_at) wait_drained();
      n++;
      if (pos_row * frm_w + pos_col < frm_w * frm_h) begin
        if ($urandom_range(0, 99) < noise_pct) send_beat(1, rand_px());
        else send_beat(0, rand_px());
      end else begin
        if ($urandom_range(0, 99) < noise_pct) send_beat(0, rand_px());
        else send_beat(1, rand_px());
      end
    end
  endtask

  task automatic test_tiny_frames();
    set_frame(1, 1, 1);
    send_beat(1, 24'hFFFFFF);
    send_beat(0, 24'h000000);
    set_frame(0, 0, 0);
    send_beat(0, 24'hFFFFFF);
    set_frame(3, 3, 2);
    for (int i = 0; i < 9; i++) send_beat(0, (i % 2) ? 24'hFFFFFF : 24'h000000);
    send_beat(0, 24'h123456);
    while (pos_row != 0 || pos_col != 0) send_beat(1, 24'h000000);
  endtask

  task automatic test_largest_kernel();
    set_frame(4, 2, 15);
    run_frame(0, -1);
    set_frame(2, 3, 14);
    run_frame(10, -1);
  endtask

  task automatic test_oversize_width();
    set_frame(2047, 1, 1);
    run_frame(0, -1);
  endtask

  task automatic test_mid_frame_pause();
    set_frame(6, 5, 5);
    run_frame(0, 12);
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 19) == 0) w = $urandom_range(1, 40);
      else w = $urandom_range(0, 10);
      h = $urandom_range(0, 6);
      set_frame(w, h, $urandom_range(0, 15));
      run_frame($urandom_range(0, 3) == 0 ? 15 : 0, $urandom_range(0, 9) == 0 ? 5 : -1);
    end
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) stall_quiet <= ~stall_quiet;
      if (stall_quiet) out_stall <= 0;
      else if (out_stall) out_stall <= ($urandom_range(0, 9) < 2);
      else out_stall <= ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin
    blur_px_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = pending_px.pop_front();
        if (out_ch0 !== e.c0) report_mismatch("out_ch0", out_ch0, e.c0);
        if (out_ch1 !== e.c1) report_mismatch("out_ch1", out_ch1, e.c1);
        if (out_ch2 !== e.c2) report_mismatch("out_ch2", out_ch2, e.c2);
        if (last_of_frame !== e.last) report_mismatch("last_of_frame", last_of_frame, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = bbf_pkg::REG_WIDTH;
    cfg_data = '0;
    in_valid = 0;
    kind = 0;
    ch0 = 0;
    ch1 = 0;
    ch2 = 0;
    out_stall = 0;
    reg_w = bbf_pkg::RST_WIDTH;
    reg_h = bbf_pkg::RST_HEIGHT;
    reg_k = bbf_pkg::RST_KERNEL;
    pos_row = 0;
    pos_col = 0;
    emit_cnt = 0;
    frm_w = 0;
    frm_h = 0;
    frm_half = 0;
    for (int i = 0; i < LINE_ROWS * LINE_W; i++) line_mem[i] = '0;
    for (int i = 0; i < KCAP; i++) col_sum[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_tiny_frames();
    test_largest_kernel();
    test_oversize_width();
    test_mid_frame_pause();
    test_random_frames();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
